/* sv/dlps_pkg.sv */
// Shared types and constants of the delay line pitch shifter.
`default_nettype none

package dlps_pkg;

	localparam int DLEN_W      = 12;
	localparam int STEP_W      = 24;
	localparam int CFG_DATA_W  = 24;
	localparam int CFG_INDEX_W = 2;

	localparam logic [CFG_INDEX_W-1:0] REG_DELAY_LENGTH = 2'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_PHASE_STEP   = 2'd1;

	localparam logic [DLEN_W-1:0] DLEN_RESET = 12'd1323;
	localparam logic [STEP_W-1:0] STEP_RESET = 24'd0;

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_MUL,
		ST_PREP,
		ST_DIV,
		ST_RD1,
		ST_RD2,
		ST_MAC2,
		ST_SUM,
		ST_OUT
	} dlps_state_t;

	typedef struct packed {
		logic load;
		logic run;
	} dlps_div_ctl_t;

endpackage

`default_nettype wire

/* sv/dlps_store.sv */
// Delay sample memory with one write port and one registered read port.
`default_nettype none

module dlps_store #(
	parameter int DEPTH = 2048,
	parameter int AW    = 11,
	parameter int DW    = 16
) (
	input  wire logic          clk,
	input  wire logic          wr_en,
	input  wire logic [AW-1:0] wr_addr,
	input  wire logic [DW-1:0] wr_data,
	input  wire logic [AW-1:0] rd_addr,
	output logic      [DW-1:0] rd_data
);

	logic [DW-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		rd_data <= mem[rd_addr];
	end

endmodule

`default_nettype wire

/* sv/dlps_mod.sv */
// Restoring remainder unit that resolves one quotient bit per cycle while run is high.
`default_nettype none

module dlps_mod
	import dlps_pkg::*;
#(
	parameter int VW = 14,
	parameter int LW = 12,
	parameter int CW = 4
) (
	input  wire logic          clk,
	input  wire dlps_div_ctl_t ctl,
	input  wire logic [VW-1:0] value,
	input  wire logic [LW-1:0] divisor,
	input  wire logic [CW-1:0] shift,
	output logic      [VW-1:0] rem
);

	localparam int DW = VW + LW;

	logic [VW-1:0] rem_q;
	logic [DW-1:0] d_sh;

	assign d_sh = DW'(divisor) << shift;

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			rem_q <= value;
		end else if (ctl.run && (d_sh <= DW'(rem_q))) begin
			rem_q <= rem_q - VW'(d_sh);
		end
	end

	assign rem = rem_q;

endmodule

`default_nettype wire

/* sv/delay_line_pitch_shifter.sv */
// Top level: two tap delay line pitch shifter with sequencer and datapath.
// An input transaction passes through MUL, PREP, DIV, RD1, RD2, MAC2, SUM and OUT before output valid.
// in_stall stays high until the sequence returns to IDLE, so a new transaction waits for the previous result.
// The three modulo reductions resolve one bit per cycle over VW = 14 steps.
// After reset the block clears every delay memory word, 0 to MAX_DELAY - 1, with in_stall high.
// Configuration writes are taken during the clear pass as at any other time.
`default_nettype none

module delay_line_pitch_shifter
	import dlps_pkg::*;
#(
	parameter int MAX_DELAY   = 2048,
	parameter int SAMPLE_BITS = 16,
	parameter int PHASE_BITS  = 24
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          cfg_write,
	input  wire logic [CFG_INDEX_W-1:0]        cfg_index,
	input  wire logic [CFG_DATA_W-1:0]         cfg_data,
	input  wire logic                          in_valid,
	output logic                               in_stall,
	input  wire logic signed [SAMPLE_BITS-1:0] sample_in,
	output logic                               out_valid,
	input  wire logic                          out_stall,
	output logic signed [SAMPLE_BITS-1:0]      sample_out
);

	localparam int AW   = (MAX_DELAY > 1) ? $clog2(MAX_DELAY) : 1;
	localparam int LW   = DLEN_W;
	localparam int VW   = ((AW > LW + 1) ? AW : LW + 1) + 1;
	localparam int CW   = $clog2(VW);
	localparam int PW   = PHASE_BITS;
	localparam int SB   = SAMPLE_BITS;
	localparam int PRW  = PW + LW;
	localparam int WW   = PW + 1;
	localparam int MW   = WW + 1 + SB;
	localparam int SUMW = MW + 1;
	localparam int YW   = SUMW - PW;

	localparam logic signed [YW-1:0] Y_MAX = YW'((1 << (SB - 1)) - 1);
	localparam logic signed [YW-1:0] Y_MIN = -Y_MAX - YW'(1);

	dlps_state_t state_q, state_d;

	logic [LW-1:0]            len_cfg_q;
	logic signed [STEP_W-1:0] step_q;
	logic [LW-1:0]            len_eff;

	logic [AW-1:0] wp_q;
	logic [PW-1:0] ph1_q, ph2_q;
	logic [AW-1:0] clr_q;
	logic [CW-1:0] cnt_q;

	logic [LW-1:0]          len_q;
	logic [SB-1:0]          sample_q;
	logic [PRW-1:0]         prod1_q, prod2_q;
	logic [WW-1:0]          w1_q, w2_q;
	logic signed [MW-1:0]   pa_q, pb_q;
	logic signed [YW-1:0]   y_q;
	logic                   out_valid_q;
	logic signed [SB-1:0]   sample_out_q;

	logic [PRW:0]    csum1, csum2;
	logic [LW:0]     c1, c2;
	logic [VW-1:0]   v1, v2, v3;
	logic [VW-1:0]   rem1, rem2, rem3;
	logic [WW-1:0]   w1_n, w2_n;
	logic [PW-1:0]   step_ext;
	logic signed [SUMW-1:0] sum_n, sum_r;
	logic signed [YW-1:0]   y_n;

	dlps_div_ctl_t div_ctl;
	logic          mem_we;
	logic [AW-1:0] mem_waddr;
	logic [SB-1:0] mem_wdata;
	logic [AW-1:0] mem_raddr;
	logic [SB-1:0] rd_data;
	logic          out_free;
	logic          out_load;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_cfg_q <= DLEN_RESET;
			step_q    <= STEP_RESET;
		end else if (cfg_write) begin
			case (cfg_index)
				REG_DELAY_LENGTH: len_cfg_q <= cfg_data[LW-1:0];
				REG_PHASE_STEP:   step_q    <= cfg_data[STEP_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		if (len_cfg_q == '0) begin
			len_eff = LW'(1);
		end else if (32'(len_cfg_q) > MAX_DELAY) begin
			len_eff = LW'(MAX_DELAY);
		end else begin
			len_eff = len_cfg_q;
		end
	end

	assign csum1 = (PRW + 1)'(prod1_q) + (((PRW + 1)'(1) << (PW - 1)) - (PRW + 1)'(1));
	assign csum2 = (PRW + 1)'(prod2_q) + (((PRW + 1)'(1) << (PW - 1)) - (PRW + 1)'(1));
	assign c1 = csum1[PW-1 +: LW+1];
	assign c2 = csum2[PW-1 +: LW+1];

	assign v1 = VW'(wp_q) + VW'({len_q, 1'b0}) - VW'(c1);
	assign v2 = VW'(wp_q) + VW'({len_q, 1'b0}) - VW'(c2);
	assign v3 = VW'(wp_q) + VW'(1);

	assign w1_n = ph1_q[PW-1] ? (((WW'(1) << PW) - WW'(ph1_q)) << 1) : (WW'(ph1_q) << 1);
	assign w2_n = ph2_q[PW-1] ? (((WW'(1) << PW) - WW'(ph2_q)) << 1) : (WW'(ph2_q) << 1);

	assign step_ext = PW'(step_q);

	assign sum_n = SUMW'(pa_q) + SUMW'(pb_q);
	assign sum_r = sum_n + SUMW'(1) * (SUMW'(1) << (PW - 1));

	always_comb begin
		y_n = sum_r[SUMW-1:PW];
		if (y_n > Y_MAX) begin
			y_n = Y_MAX;
		end else if (y_n < Y_MIN) begin
			y_n = Y_MIN;
		end
	end

	assign out_free = !out_valid_q || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		div_ctl   = '0;
		mem_we    = 1'b0;
		mem_waddr = wp_q;
		mem_wdata = sample_q;
		mem_raddr = AW'(rem2);
		out_load  = 1'b0;
		in_stall  = 1'b1;
		case (state_q)
			ST_CLEAR: begin
				mem_we    = 1'b1;
				mem_waddr = clr_q;
				mem_wdata = '0;
				if (clr_q == AW'(MAX_DELAY - 1)) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					state_d = ST_MUL;
				end
			end
			ST_MUL: state_d = ST_PREP;
			ST_PREP: begin
				div_ctl.load = 1'b1;
				state_d      = ST_DIV;
			end
			ST_DIV: begin
				div_ctl.run = 1'b1;
				if (cnt_q == '0) begin
					state_d = ST_RD1;
				end
			end
			ST_RD1: begin
				mem_raddr = AW'(rem1);
				state_d   = ST_RD2;
			end
			ST_RD2:  state_d = ST_MAC2;
			ST_MAC2: state_d = ST_SUM;
			ST_SUM: begin
				mem_we  = 1'b1;
				state_d = ST_OUT;
			end
			ST_OUT: begin
				if (out_free) begin
					out_load = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			ph1_q <= '0;
			ph2_q <= PW'(1) << (PW - 1);
			clr_q <= '0;
			cnt_q <= '0;
		end else begin
			if (state_q == ST_CLEAR) begin
				clr_q <= clr_q + AW'(1);
			end
			if (state_q == ST_PREP) begin
				cnt_q <= CW'(VW - 1);
			end else if (state_q == ST_DIV) begin
				cnt_q <= cnt_q - CW'(1);
			end
			if (state_q == ST_SUM) begin
				wp_q  <= AW'(rem3);
				ph1_q <= ph1_q + step_ext;
				ph2_q <= ph2_q + step_ext;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && in_valid) begin
			sample_q <= sample_in;
			len_q    <= len_eff;
		end
		if (state_q == ST_MUL) begin
			prod1_q <= PRW'(ph1_q) * PRW'(len_q);
			prod2_q <= PRW'(ph2_q) * PRW'(len_q);
			w1_q    <= w1_n;
			w2_q    <= w2_n;
		end
		if (state_q == ST_RD2) begin
			pa_q <= MW'($signed({1'b0, w1_q})) * MW'($signed(rd_data));
		end
		if (state_q == ST_MAC2) begin
			pb_q <= MW'($signed({1'b0, w2_q})) * MW'($signed(rd_data));
		end
		if (state_q == ST_SUM) begin
			y_q <= y_n;
		end
		if (out_load) begin
			sample_out_q <= SB'(y_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid  = out_valid_q;
	assign sample_out = sample_out_q;

	dlps_mod #(.VW(VW), .LW(LW), .CW(CW)) u_mod_tap1 (
		.clk     (clk),
		.ctl     (div_ctl),
		.value   (v1),
		.divisor (len_q),
		.shift   (cnt_q),
		.rem     (rem1)
	);

	dlps_mod #(.VW(VW), .LW(LW), .CW(CW)) u_mod_tap2 (
		.clk     (clk),
		.ctl     (div_ctl),
		.value   (v2),
		.divisor (len_q),
		.shift   (cnt_q),
		.rem     (rem2)
	);

	dlps_mod #(.VW(VW), .LW(LW), .CW(CW)) u_mod_wp (
		.clk     (clk),
		.ctl     (div_ctl),
		.value   (v3),
		.divisor (len_q),
		.shift   (cnt_q),
		.rem     (rem3)
	);

	dlps_store #(.DEPTH(MAX_DELAY), .AW(AW), .DW(SB)) u_store (
		.clk     (clk),
		.wr_en   (mem_we),
		.wr_addr (mem_waddr),
		.wr_data (mem_wdata),
		.rd_addr (mem_raddr),
		.rd_data (rd_data)
	);

`ifndef NO_ASSERTIONS
	ap_clear_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_CLEAR) |-> in_stall)
		else $error("input transaction possible during memory clear");

	ap_tap_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_RD1) |-> ((rem1 < VW'(len_q)) && (rem2 < VW'(len_q))))
		else $error("tap index not reduced below delay length");

	ap_wp_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SUM) |=> (VW'(wp_q) < VW'(len_q)))
		else $error("write pointer not reduced below delay length");

	ap_out_load: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_OUT && out_free) |=> (out_valid && state_q == ST_IDLE))
		else $error("result not presented after sequence end");
`endif

endmodule

`default_nettype wire
